>>> rtl/partition_fit_allocator_assert.svh
`ifndef PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PFA_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("partition fit allocator check failed");
`define PFA_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("partition fit allocator check failed");
`else
`define PFA_ASSERT(name, clk, rst_n, prop)
`define PFA_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

	localparam int LEN_W    = 16;
	localparam int LIMIT_W  = 17;
	localparam int FLOOR_W  = 16;
	localparam int POLICY_W = 2;
	localparam int CFG_W    = 17;
	localparam int FIELD_W  = 16;

	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	localparam logic [1:0] CFG_POLICY = 2'd0;
	localparam logic [1:0] CFG_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_FLOOR  = 2'd2;

	localparam logic [1:0] STAT_ALLOC  = 2'd0;
	localparam logic [1:0] STAT_NOFIT  = 2'd1;
	localparam logic [1:0] STAT_LOADED = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1000;
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd50;

	typedef struct packed {
		logic [POLICY_W-1:0] policy;
		logic [LIMIT_W-1:0]  limit;
		logic [FLOOR_W-1:0]  floor;
	} cfg_t;

	typedef struct packed {
		logic             found;
		logic [LEN_W-1:0] best_left;
	} pick_t;

endpackage

>>> rtl/pfa_ram.sv
`timescale 1ns / 1ps

module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/pfa_fit.sv
`timescale 1ns / 1ps

module pfa_fit (
	input  pfa_pkg::cfg_t                cfg,
	input  pfa_pkg::pick_t               pick,
	input  logic [pfa_pkg::LEN_W-1:0]    want,
	input  logic                         cand_free,
	input  logic [pfa_pkg::LEN_W-1:0]    cand_len,
	output logic                         take,
	output logic [pfa_pkg::LEN_W-1:0]    left
);

	logic                          fits;
	logic [pfa_pkg::LIMIT_W-1:0]   best_bound;
	logic [pfa_pkg::FLOOR_W-1:0]   worst_bound;

	assign fits        = cand_free && (cand_len >= want);
	assign left        = cand_len - want;
	assign best_bound  = pick.found ? pfa_pkg::LIMIT_W'(pick.best_left) : cfg.limit;
	assign worst_bound = pick.found ? pfa_pkg::FLOOR_W'(pick.best_left) : cfg.floor;

	always_comb begin
		unique case (cfg.policy)
			pfa_pkg::POL_BEST: begin
				take = fits && (pfa_pkg::LIMIT_W'(left) < best_bound);
			end
			pfa_pkg::POL_WORST: begin
				take = fits && (pfa_pkg::FLOOR_W'(left) > worst_bound);
			end
			default: begin
				take = fits && !pick.found;
			end
		endcase
	end

endmodule

>>> rtl/partition_fit_allocator.sv
`timescale 1ns / 1ps

// Segment allocator over a table kept in load order in one RAM. An item is
// taken when start is high and busy is low; its single result appears on
// status and alloc_address for exactly one cycle with done high, and must be
// captured then since the block cannot be stalled. The result of a load
// shows in the cycle after it is taken. An allocate reads the table one
// entry per cycle through the RAM port, then, when a remainder is left,
// moves every entry above the chosen one up by one entry per cycle to open
// a slot for the split remainder.

`include "partition_fit_allocator_assert.svh"

module partition_fit_allocator #(
	parameter int MAX_SEGMENTS = 32,
	parameter int ADDR_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [pfa_pkg::FIELD_W-1:0]   seg_base,
	input  logic [pfa_pkg::FIELD_W-1:0]   req_size,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [pfa_pkg::FIELD_W-1:0]   alloc_address,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]     cfg_data
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW = ADDR_BITS + pfa_pkg::LEN_W + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_RESOLVE = 6'b000100,
		ST_SHIFT   = 6'b001000,
		ST_SPLIT   = 6'b010000,
		ST_MARK    = 6'b100000
	} state_t;

	state_t                         state_q;
	pfa_pkg::cfg_t                  cfg_q;
	logic [CW-1:0]                  count_q;
	logic [pfa_pkg::LEN_W-1:0]      size_q;
	logic [IW-1:0]                  scan_q;
	logic [IW-1:0]                  sh_q;
	logic [IW-1:0]                  pick_q;
	pfa_pkg::pick_t                 pick_info_q;
	logic [ADDR_BITS-1:0]           pick_base_q;
	logic [pfa_pkg::LEN_W-1:0]      pick_len_q;
	logic                           done_q;
	logic [1:0]                     status_q;
	logic [pfa_pkg::FIELD_W-1:0]    addr_q;

	logic                           ram_we;
	logic [IW-1:0]                  ram_waddr;
	logic [EW-1:0]                  ram_wdata;
	logic [IW-1:0]                  ram_raddr;
	logic [EW-1:0]                  ram_rdata;

	logic [ADDR_BITS-1:0]           base_in;
	logic [ADDR_BITS-1:0]           rd_base;
	logic [pfa_pkg::LEN_W-1:0]      rd_len;
	logic                           rd_free;
	logic                           fit_take;
	logic [pfa_pkg::LEN_W-1:0]      fit_left;
	logic [pfa_pkg::LEN_W-1:0]      pick_left;
	logic                           accept;
	logic                           scan_last;

	assign base_in   = ADDR_BITS'(seg_base);
	assign rd_base   = ram_rdata[ADDR_BITS-1:0];
	assign rd_len    = ram_rdata[ADDR_BITS +: pfa_pkg::LEN_W];
	assign rd_free   = ram_rdata[EW-1];
	assign pick_left = pick_len_q - size_q;
	assign accept    = start && (state_q == ST_IDLE);
	assign scan_last = (CW'(scan_q) == (count_q - CW'(1)));

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign alloc_address = addr_q;

	pfa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pfa_fit u_fit (
		.cfg       (cfg_q),
		.pick      (pick_info_q),
		.want      (size_q),
		.cand_free (rd_free),
		.cand_len  (rd_len),
		.take      (fit_take),
		.left      (fit_left)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = {1'b1, req_size, base_in};
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_we    = accept && (mode == pfa_pkg::MODE_LOAD) && (count_q != MAX_CNT);
				ram_waddr = IW'(count_q);
			end
			ST_SCAN: begin
				ram_raddr = scan_q + IW'(1);
			end
			ST_RESOLVE: begin
				ram_raddr = IW'(count_q - CW'(1));
			end
			ST_SHIFT: begin
				ram_raddr = sh_q - IW'(1);
				ram_we    = 1'b1;
				ram_waddr = sh_q + IW'(1);
				ram_wdata = ram_rdata;
			end
			ST_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = pick_q + IW'(1);
				ram_wdata = {1'b1, pick_left, pick_base_q + ADDR_BITS'(size_q)};
			end
			ST_MARK: begin
				ram_we    = 1'b1;
				ram_waddr = pick_q;
				ram_wdata = {1'b0, size_q, pick_base_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy <= pfa_pkg::POL_FIRST;
			cfg_q.limit  <= pfa_pkg::LIMIT_RESET;
			cfg_q.floor  <= pfa_pkg::FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfa_pkg::CFG_POLICY: cfg_q.policy <= cfg_data[pfa_pkg::POLICY_W-1:0];
				pfa_pkg::CFG_LIMIT:  cfg_q.limit  <= cfg_data[pfa_pkg::LIMIT_W-1:0];
				pfa_pkg::CFG_FLOOR:  cfg_q.floor  <= cfg_data[pfa_pkg::FLOOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			count_q           <= '0;
			done_q            <= 1'b0;
			pick_info_q.found <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						size_q            <= req_size;
						scan_q            <= '0;
						pick_info_q.found <= 1'b0;
						addr_q            <= '0;
						if (mode == pfa_pkg::MODE_LOAD) begin
							done_q <= 1'b1;
							if (count_q == MAX_CNT) begin
								status_q <= pfa_pkg::STAT_FULL;
							end else begin
								status_q <= pfa_pkg::STAT_LOADED;
								count_q  <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							done_q   <= 1'b1;
							status_q <= pfa_pkg::STAT_NOFIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (fit_take) begin
						pick_info_q.found     <= 1'b1;
						pick_info_q.best_left <= fit_left;
						pick_q                <= scan_q;
						pick_base_q           <= rd_base;
						pick_len_q            <= rd_len;
					end
					if (scan_last) begin
						state_q <= ST_RESOLVE;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				ST_RESOLVE: begin
					sh_q <= IW'(count_q - CW'(1));
					if (!pick_info_q.found) begin
						done_q   <= 1'b1;
						status_q <= pfa_pkg::STAT_NOFIT;
						state_q  <= ST_IDLE;
					end else if (pick_left == '0) begin
						state_q <= ST_MARK;
					end else if (count_q == MAX_CNT) begin
						done_q   <= 1'b1;
						status_q <= pfa_pkg::STAT_FULL;
						state_q  <= ST_IDLE;
					end else if (count_q > (CW'(pick_q) + CW'(1))) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SHIFT: begin
					if (sh_q == (pick_q + IW'(1))) begin
						state_q <= ST_SPLIT;
					end else begin
						sh_q <= sh_q - IW'(1);
					end
				end
				ST_SPLIT: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					done_q   <= 1'b1;
					status_q <= pfa_pkg::STAT_ALLOC;
					addr_q   <= pfa_pkg::FIELD_W'(pick_base_q);
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PFA_ASSERT(a_count_bound, clk, arst_n, count_q <= MAX_CNT)
	`PFA_ASSERT(a_load_one_cycle, clk, arst_n, accept && (mode == pfa_pkg::MODE_LOAD) |=> done_q)
	`PFA_ASSERT(a_addr_zero, clk, arst_n, done_q && (status_q != pfa_pkg::STAT_ALLOC) |-> addr_q == '0)
	`PFA_ASSERT(a_shift_above_pick, clk, arst_n, (state_q == ST_SHIFT) |-> (sh_q > pick_q))
	`PFA_ASSERT(a_busy_no_done, clk, arst_n, (state_q != ST_IDLE) && (state_q != ST_SCAN) |-> !done_q || $past(state_q) != ST_IDLE)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import pfa_pkg::*;

	localparam int MAX_SEGS = 32;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 60;
	localparam int RANDOM_PHASES = 8;
	localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

	typedef struct {
		logic             mode;
		logic [15:0]      base;
		logic [15:0]      size;
	} seg_request_t;

	typedef struct {
		logic [1:0]       status;
		logic [15:0]      addr;
	} seg_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 mode = MODE_LOAD;
	logic [FIELD_W-1:0]   seg_base = '0;
	logic [FIELD_W-1:0]   req_size = '0;
	logic                 done;
	logic [1:0]           status;
	logic [FIELD_W-1:0]   alloc_address;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = CFG_POLICY;
	logic [CFG_W-1:0]     cfg_data = '0;

	partition_fit_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.seg_base(seg_base),
		.req_size(req_size),
		.done(done),
		.status(status),
		.alloc_address(alloc_address),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the segment table and the registers
	logic [15:0]          tab_base [MAX_SEGS];
	logic [15:0]          tab_len [MAX_SEGS];
	logic                 tab_free [MAX_SEGS];
	int                   tab_count = 0;
	logic [POLICY_W-1:0]  cur_policy = POL_FIRST;
	logic [LIMIT_W-1:0]   cur_limit = LIMIT_RESET;
	logic [FLOOR_W-1:0]   cur_floor = FLOOR_RESET;

	seg_request_t         pending_requests [$];
	seg_result_t          expected_results [$];
	seg_request_t         cur_req;
	int                   gap_left = 0;
	int                   gap_max = 19;
	int                   failures = 0;
	int                   idle_cycles = 0;
	logic                 timed_out = 1'b0;

	task automatic apply_request(input seg_request_t rq);
		seg_result_t res;
		int i;
		int k;
		logic found;
		logic [16:0] bound;
		logic [15:0] left;
		logic [15:0] best_left;
		res.status = STAT_NOFIT;
		res.addr = '0;
		if (rq.mode == MODE_LOAD) begin
			if (tab_count >= MAX_SEGS) begin
				res.status = STAT_FULL;
			end else begin
				tab_base[tab_count] = rq.base;
				tab_len[tab_count] = rq.size;
				tab_free[tab_count] = 1'b1;
				tab_count++;
				res.status = STAT_LOADED;
			end
		end else begin
			found = 1'b0;
			k = 0;
			best_left = '0;
			for (i = 0; i < tab_count; i++) begin
				if (tab_free[i] && tab_len[i] >= rq.size) begin
					left = tab_len[i] - rq.size;
					if (cur_policy == POL_BEST) begin
						bound = found ? {1'b0, best_left} : cur_limit;
						if ({1'b0, left} < bound) begin
							found = 1'b1;
							k = i;
							best_left = left;
						end
					end else if (cur_policy == POL_WORST) begin
						bound = found ? {1'b0, best_left} : {1'b0, cur_floor};
						if ({1'b0, left} > bound) begin
							found = 1'b1;
							k = i;
							best_left = left;
						end
					end else if (!found) begin
						found = 1'b1;
						k = i;
					end
				end
			end
			if (found) begin
				left = tab_len[k] - rq.size;
				if (left != 0 && tab_count >= MAX_SEGS) begin
					res.status = STAT_FULL;
				end else begin
					if (left != 0) begin
						for (i = tab_count; i > k + 1; i--) begin
							tab_base[i] = tab_base[i-1];
							tab_len[i] = tab_len[i-1];
							tab_free[i] = tab_free[i-1];
						end
						tab_base[k+1] = tab_base[k] + rq.size;
						tab_len[k+1] = left;
						tab_free[k+1] = 1'b1;
						tab_len[k] = rq.size;
						tab_count++;
					end
					tab_free[k] = 1'b0;
					res.status = STAT_ALLOC;
					res.addr = tab_base[k];
				end
			end
		end
		expected_results.push_back(res);
	endtask

	task automatic queue_request(input logic m, input logic [15:0] b, input logic [15:0] s);
		seg_request_t rq;
		rq.mode = m;
		rq.base = b;
		rq.size = s;
		pending_requests.push_back(rq);
	endtask

	task automatic queue_random_request();
		int r;
		int k;
		int n;
		int len;
		int d;
		int sz;
		r = $urandom_range(0, 99);
		sz = $urandom_range(0, 2000);
		if (r < 15) begin
			if ($urandom_range(0, 1) == 0)
				sz = $urandom_range(0, 65535);
			queue_request(MODE_LOAD, 16'($urandom), 16'(sz));
		end else if (r < 25 || tab_count == 0) begin
			if (r < 20)
				sz = $urandom_range(0, 65535);
			queue_request(MODE_ALLOC, 16'($urandom), 16'(sz));
		end else begin
			k = $urandom_range(0, tab_count - 1);
			for (n = 0; n < 4 && !tab_free[k]; n++)
				k = $urandom_range(0, tab_count - 1);
			len = tab_len[k];
			case ($urandom_range(0, 5))
				0: sz = len;
				1: begin
					d = $urandom_range(0, 60);
					sz = (len > d) ? len - d : 0;
				end
				2: begin
					d = $urandom_range(0, 1100);
					sz = (len > d) ? len - d : 0;
				end
				3: sz = 0;
				4: sz = $urandom_range(0, 2000);
				default: sz = (len < 65535) ? len + 1 : len;
			endcase
			queue_request(MODE_ALLOC, 16'($urandom), 16'(sz));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_POLICY: cur_policy = data[POLICY_W-1:0];
			CFG_LIMIT:  cur_limit = data[LIMIT_W-1:0];
			CFG_FLOOR:  cur_floor = data[FLOOR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_policy(input logic [POLICY_W-1:0] pol);
		write_reg(CFG_POLICY, {15'($urandom), pol});
	endtask

	// checked away from the rising edge so the driver's updates have settled
	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_results.size() != 0 || start || busy)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_LOAD;
			seg_base <= '0;
			req_size <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				apply_request(cur_req);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					mode <= cur_req.mode;
					seg_base <= cur_req.base;
					req_size <= cur_req.size;
					start <= 1'b1;
					if (gap_max > 0 && $urandom_range(0, 3) != 0)
						gap_left <= $urandom_range(0, gap_max);
					else
						gap_left <= 0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		seg_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word: status %0d address %h", status, alloc_address);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					failures++;
				end
				if (alloc_address !== want.addr) begin
					$error("alloc_address: expected %h, actual %h", want.addr, alloc_address);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT)
				timed_out <= 1'b1;
		end
	end

	initial begin
		wait (timed_out);
		$display("** partition_fit_allocator: FAILED **");
		$finish;
	end

	initial begin
		int p;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first fit on an empty table, zero lengths, field extremes
		queue_request(MODE_ALLOC, 16'hFFFF, 16'd0);
		queue_request(MODE_LOAD, 16'h0000, 16'd0);
		queue_request(MODE_LOAD, 16'hFFFF, 16'hFFFF);
		queue_request(MODE_LOAD, 16'd100, 16'd500);
		queue_request(MODE_LOAD, 16'd1000, 16'd2000);
		queue_request(MODE_LOAD, 16'd5000, 16'd300);
		queue_request(MODE_ALLOC, 16'h0000, 16'd0);
		queue_request(MODE_ALLOC, 16'h0000, 16'hFFFF);
		queue_request(MODE_ALLOC, 16'h0000, 16'd200);
		queue_request(MODE_ALLOC, 16'h0000, 16'd0);
		queue_request(MODE_ALLOC, 16'h0000, 16'd3000);
		wait_drained();

		// best fit with a tie and an address wrap
		set_policy(POL_BEST);
		queue_request(MODE_LOAD, 16'hFF00, 16'h0200);
		queue_request(MODE_ALLOC, 16'h0000, 16'd290);
		queue_request(MODE_ALLOC, 16'h0000, 16'h0180);
		queue_request(MODE_ALLOC, 16'h0000, 16'd300);
		wait_drained();

		// worst fit
		set_policy(POL_WORST);
		queue_request(MODE_ALLOC, 16'h0000, 16'd100);
		queue_request(MODE_ALLOC, 16'h0000, 16'd2000);
		queue_request(MODE_ALLOC, 16'h0000, 16'd1);
		wait_drained();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					set_policy(POL_FIRST);
					write_reg(CFG_LIMIT, 17'd1000);
					write_reg(CFG_FLOOR, {1'b1, 16'd50});
					gap_max = 19;
				end
				1: begin
					set_policy(POL_BEST);
					write_reg(CFG_LIMIT, 17'd0);
					gap_max = 0;
				end
				2: begin
					write_reg(CFG_LIMIT, 17'd65536);
					gap_max = 19;
				end
				3: begin
					set_policy(POL_WORST);
					write_reg(CFG_FLOOR, {1'b0, 16'd0});
				end
				4: begin
					write_reg(CFG_FLOOR, {1'b1, 16'hFFFF});
					gap_max = 0;
				end
				5: begin
					set_policy(POL_SPARE);
					write_reg(CFG_LIMIT, 17'd300);
					write_reg(CFG_FLOOR, {1'b0, 16'd10});
					gap_max = 19;
				end
				6: begin
					set_policy(POL_BEST);
					write_reg(CFG_LIMIT, 17'd64);
					write_reg(CFG_FLOOR, {1'b1, 16'd7});
				end
				default: begin
					set_policy(POL_WORST);
					write_reg(CFG_LIMIT, 17'd500);
					write_reg(CFG_FLOOR, {1'b0, 16'd20});
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				queue_random_request();
				// refill in small batches so targeted sizes follow the table
				if (n % 10 == 9)
					wait_drained();
			end
			wait_drained();
		end

		repeat (80) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0)
			$display("** partition_fit_allocator: PASSED **");
		else
			$display("** partition_fit_allocator: FAILED **");
		$finish;
	end

endmodule
